// ===== sv/kls_pkg.sv =====
// Package: shared constants, types and the population count function of the keypad line probe scan.
`timescale 1ns / 1ps
`default_nettype none

package kls_pkg;

  // Number of keypad lines; lines at or above this count are ignored
  localparam int LINE_COUNT = 16;

  // Mask of the lines that exist
  localparam logic [15:0] LINE_SPAN =
    (LINE_COUNT >= 16) ? 16'hFFFF : 16'((64'd1 << LINE_COUNT) - 64'd1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIGURED_LINES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW_LINES = 1'd1;

  // Reset values of the configuration registers
  localparam logic [15:0] CONFIGURED_RESET = 16'h0000;
  localparam logic [15:0] ACTIVE_LOW_RESET = 16'hFFFF;

  // Outcome of one probe step
  typedef struct packed {
    logic        last_step;
    logic        has_hits;
    logic [3:0]  strobe_line;
    logic [15:0] drive_bit;
    logic [15:0] hit_bits;
    logic [3:0]  hit_total;
  } probe_t;

  // Scan summary, all zero unless scan_done
  typedef struct packed {
    logic        scan_done;
    logic [15:0] activity_mask;
    logic [4:0]  activity_count;
    logic        best_found;
    logic [3:0]  best_drive;
    logic [15:0] best_mask;
    logic [3:0]  best_count;
  } summary_t;

  // Population count of 16 bits as an adder tree
  function automatic logic [4:0] ones16(input logic [15:0] v);
    logic [1:0] s1 [8];
    logic [2:0] s2 [4];
    logic [3:0] s3 [2];
    for (int i = 0; i < 8; i++) begin
      s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    end
    return {1'b0, s3[0]} + {1'b0, s3[1]};
  endfunction

endpackage

`default_nettype wire

// ===== sv/kls_in_if.sv =====
// Interface: input channel carrying one probe step item.
`timescale 1ns / 1ps
`default_nettype none

interface kls_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  strobe_line;
  logic [15:0] sense_levels;
  logic        last_step;

  modport source (output valid, output strobe_line, output sense_levels,
                  output last_step, input ready);
  modport sink (input valid, input strobe_line, input sense_levels,
                input last_step, output ready);
endinterface

`default_nettype wire

// ===== sv/kls_out_if.sv =====
// Interface: result channel carrying one probe result item.
`timescale 1ns / 1ps
`default_nettype none

interface kls_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] hit_bits;
  logic [3:0]  hit_total;
  logic        scan_done;
  logic [15:0] activity_mask;
  logic [4:0]  activity_count;
  logic        best_found;
  logic [3:0]  best_drive;
  logic [15:0] best_mask;
  logic [3:0]  best_count;

  modport source (output valid, output hit_bits, output hit_total, output scan_done,
                  output activity_mask, output activity_count, output best_found,
                  output best_drive, output best_mask, output best_count,
                  input ready);
  modport sink (input valid, input hit_bits, input hit_total, input scan_done,
                input activity_mask, input activity_count, input best_found,
                input best_drive, input best_mask, input best_count,
                output ready);
endinterface

`default_nettype wire

// ===== sv/kls_probe.sv =====
// Probe step logic: polarity correction, hit masking and hit count.
`timescale 1ns / 1ps
`default_nettype none

module kls_probe (
  input  wire logic [3:0]    strobe_line,
  input  wire logic [15:0]   sense_levels,
  input  wire logic          last_step,
  input  wire logic [15:0]   configured_lines,
  input  wire logic [15:0]   active_low_lines,
  output kls_pkg::probe_t    probe
);

  logic [15:0] cfg;
  logic [15:0] active;
  logic [15:0] drive_bit;
  logic [15:0] hits;
  logic [4:0]  count;

  // Driven line decode; lines beyond the span give no bit
  always_comb begin
    cfg       = configured_lines & kls_pkg::LINE_SPAN;
    active    = (sense_levels ^ active_low_lines) & kls_pkg::LINE_SPAN;
    drive_bit = (16'd1 << strobe_line) & kls_pkg::LINE_SPAN;
    hits      = '0;
    if ((cfg & drive_bit) != 16'd0) begin
      hits = active & cfg & ~drive_bit;
    end
    count = kls_pkg::ones16(hits);
  end

  // Pack the step outcome
  always_comb begin
    probe.last_step   = last_step;
    probe.has_hits    = (hits != 16'd0);
    probe.strobe_line = strobe_line;
    probe.drive_bit   = drive_bit;
    probe.hit_bits    = hits;
    probe.hit_total   = count[3:0];  // driven line never counts, so at most 15
  end

endmodule

`default_nettype wire

// ===== sv/kls_accum.sv =====
// Scan accumulator: activity mask, strongest probe and end-of-scan summary.
`timescale 1ns / 1ps
`default_nettype none

module kls_accum (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step_en,
  input  wire kls_pkg::probe_t probe,
  output kls_pkg::summary_t  summary
);

  logic [15:0] seen_r,  seen_nxt;
  logic        top_valid_r, top_valid_nxt;
  logic [3:0]  top_line_r,  top_line_nxt;
  logic [15:0] top_hits_r,  top_hits_nxt;
  logic [3:0]  top_count_r, top_count_nxt;

  // State after this step, before any end-of-scan clear
  always_comb begin
    seen_nxt      = seen_r;
    top_valid_nxt = top_valid_r;
    top_line_nxt  = top_line_r;
    top_hits_nxt  = top_hits_r;
    top_count_nxt = top_count_r;
    if (probe.has_hits) begin
      seen_nxt = seen_r | probe.drive_bit | probe.hit_bits;
      if (probe.hit_total > top_count_r) begin
        top_valid_nxt = 1'b1;
        top_line_nxt  = probe.strobe_line;
        top_hits_nxt  = probe.hit_bits;
        top_count_nxt = probe.hit_total;
      end
    end
  end

  // Summary includes this step; zero except on the last step
  always_comb begin
    summary = '0;
    if (probe.last_step) begin
      summary.scan_done      = 1'b1;
      summary.activity_mask  = seen_nxt;
      summary.activity_count = kls_pkg::ones16(seen_nxt);
      summary.best_found     = top_valid_nxt;
      summary.best_drive     = top_line_nxt;
      summary.best_mask      = top_hits_nxt;
      summary.best_count     = top_count_nxt;
    end
  end

  // Scan state, cleared after the last step
  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && probe.last_step)) begin
      seen_r      <= '0;
      top_valid_r <= 1'b0;
      top_line_r  <= '0;
      top_hits_r  <= '0;
      top_count_r <= '0;
    end else if (step_en) begin
      seen_r      <= seen_nxt;
      top_valid_r <= top_valid_nxt;
      top_line_r  <= top_line_nxt;
      top_hits_r  <= top_hits_nxt;
      top_count_r <= top_count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/keypad_line_probe_scan.sv =====
// Top level: keypad line probe scan with input and result registers.
//
//  Channel  Direction  Handshake        Contents
//  in_ch    sink       valid / ready    strobe_line, sense_levels, last_step
//  out_ch   source     valid / ready    hit mask and count, scan summary
//  cfg_*    sink       cfg_we           cfg_index, cfg_data (16 bits)
//
// One item per cycle sustained while out_ch is ready; an item passes the item register, then the result register.
// Item register feeds the probe logic and accumulator, which load the result register.
// Synchronous active-low reset clears scan state and sets the config reset values.
// With the result stalled, one further item is held in the item register.
`timescale 1ns / 1ps
`default_nettype none

module keypad_line_probe_scan (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  kls_in_if.sink                             in_ch,
  kls_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [kls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data
);

  logic [15:0] configured_r;
  logic [15:0] active_low_r;

  logic        in_valid_r;
  logic [3:0]  drive_r;
  logic [15:0] levels_r;
  logic        last_r;

  logic        out_valid_r;
  logic [15:0] hit_bits_r;
  logic [3:0]  hit_total_r;
  kls_pkg::summary_t summary_r;

  logic        advance;
  kls_pkg::probe_t   probe;
  kls_pkg::summary_t summary;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      configured_r <= kls_pkg::CONFIGURED_RESET;
      active_low_r <= kls_pkg::ACTIVE_LOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        kls_pkg::CFG_CONFIGURED_LINES: configured_r <= cfg_data;
        kls_pkg::CFG_ACTIVE_LOW_LINES: active_low_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: item moves on when the result register is free or emptying
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  // Item register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      drive_r  <= in_ch.strobe_line;
      levels_r <= in_ch.sense_levels;
      last_r   <= in_ch.last_step;
    end
  end

  kls_probe u_probe (
    .strobe_line      (drive_r),
    .sense_levels     (levels_r),
    .last_step        (last_r),
    .configured_lines (configured_r),
    .active_low_lines (active_low_r),
    .probe            (probe)
  );

  kls_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .probe   (probe),
    .summary (summary)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit_bits_r  <= probe.hit_bits;
      hit_total_r <= probe.hit_total;
      summary_r   <= summary;
    end
  end

  // Result channel
  assign out_ch.valid          = out_valid_r;
  assign out_ch.hit_bits       = hit_bits_r;
  assign out_ch.hit_total      = hit_total_r;
  assign out_ch.scan_done      = summary_r.scan_done;
  assign out_ch.activity_mask  = summary_r.activity_mask;
  assign out_ch.activity_count = summary_r.activity_count;
  assign out_ch.best_found     = summary_r.best_found;
  assign out_ch.best_drive     = summary_r.best_drive;
  assign out_ch.best_mask      = summary_r.best_mask;
  assign out_ch.best_count     = summary_r.best_count;

endmodule

`default_nettype wire

// ===== tb/tb_keypad_line_probe_scan.sv =====
// Testbench for the keypad line probe scan: directed table plus random scans.
`timescale 1ns / 1ps

module tb_keypad_line_probe_scan;

  localparam int IDLE_LIMIT = 2000;  // cycles with no item moving on either side
  localparam int HOLD_CYCLES = 80;   // long receiver hold-off
  localparam int TAIL_CYCLES = 8;    // settle time after the last result
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 116;
  localparam int DIR_N = 25;

  // One result item as the block presents it
  typedef struct packed {
    logic [15:0] hit_bits;
    logic [3:0]  hit_total;
    logic        scan_done;
    logic [15:0] activity_mask;
    logic [4:0]  activity_count;
    logic        best_found;
    logic [3:0]  best_drive;
    logic [15:0] best_mask;
    logic [3:0]  best_count;
  } probe_res_t;

  // Directed row: either a register setting or a probe step
  typedef struct packed {
    logic        is_cfg;
    logic [15:0] conf;
    logic [15:0] alow;
    logic [3:0]  drive;
    logic [15:0] levels;
    logic        last;
    logic        pinned;
    logic [15:0] pin_mask;
    logic [3:0]  pin_count;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [kls_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  kls_in_if  in_bus ();
  kls_out_if out_bus ();

  keypad_line_probe_scan dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of registers and scan state
  logic [15:0] lines_cfg;
  logic [15:0] lines_alow;
  logic [15:0] scan_seen;
  logic        best_ok;
  logic [3:0]  best_line;
  logic [15:0] best_hits;
  logic [3:0]  best_hits_n;

  probe_res_t probe_results_due [$];

  // Run control shared between processes
  bit          idle_on;
  bit          hold_req;
  bit          pin_now;
  logic [15:0] pin_mask;
  logic [3:0]  pin_cnt;
  int          mismatches;
  int          stall_cycles;
  int          steps_sent;
  int          scans_seen;
  int          results_checked;
  int          settings_used;

  dir_row_t dir_tab [DIR_N];

  always #10 clk = ~clk;

  // Expected result of one probe step; advances the predictor's scan state
  function automatic probe_res_t predict_probe(logic [3:0] drv, logic [15:0] lv, logic lst);
    logic [15:0] dbit;
    logic [15:0] hits;
    logic [4:0]  cnt;
    probe_res_t  r;
    dbit = 16'h0000;
    hits = 16'h0000;
    if (int'(drv) < kls_pkg::LINE_COUNT) begin
      dbit = 16'h0001 << drv;
    end
    // unconfigured driven line: no hits at all
    if ((lines_cfg & kls_pkg::LINE_SPAN & dbit) != 16'h0000) begin
      hits = (lv ^ lines_alow) & kls_pkg::LINE_SPAN & lines_cfg & ~dbit;
    end
    cnt = 5'($countones(hits));
    if (hits != 16'h0000) begin
      scan_seen = scan_seen | dbit | hits;
      // only a strictly stronger probe replaces the stored one
      if (cnt > {1'b0, best_hits_n}) begin
        best_ok = 1'b1;
        best_line = drv;
        best_hits = hits;
        best_hits_n = cnt[3:0];
      end
    end
    r = '0;
    r.hit_bits = hits;
    r.hit_total = cnt[3:0];
    if (lst) begin
      r.scan_done = 1'b1;
      r.activity_mask = scan_seen;
      r.activity_count = 5'($countones(scan_seen));
      r.best_found = best_ok;
      r.best_drive = best_line;
      r.best_mask = best_hits;
      r.best_count = best_hits_n;
      scan_seen = '0;
      best_ok = 1'b0;
      best_line = '0;
      best_hits = '0;
      best_hits_n = '0;
    end
    return r;
  endfunction

  task automatic cmp_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
    end
  endtask

  // Monitor: check results, predict accepted items, watchdog
  always @(posedge clk) begin
    probe_res_t want;
    probe_res_t got;
    bit moved;
    moved = 1'b0;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      moved = 1'b1;
      got = '{out_bus.hit_bits, out_bus.hit_total, out_bus.scan_done,
              out_bus.activity_mask, out_bus.activity_count, out_bus.best_found,
              out_bus.best_drive, out_bus.best_mask, out_bus.best_count};
      if (probe_results_due.size() == 0) begin
        mismatches++;
        $error("result item arrived with no probe step outstanding");
      end else begin
        want = probe_results_due.pop_front();
        results_checked++;
        if (got.scan_done) scans_seen++;
        cmp_field("hit_bits", want.hit_bits, got.hit_bits);
        cmp_field("hit_total", want.hit_total, got.hit_total);
        cmp_field("scan_done", want.scan_done, got.scan_done);
        cmp_field("activity_mask", want.activity_mask, got.activity_mask);
        cmp_field("activity_count", want.activity_count, got.activity_count);
        cmp_field("best_found", want.best_found, got.best_found);
        cmp_field("best_drive", want.best_drive, got.best_drive);
        cmp_field("best_mask", want.best_mask, got.best_mask);
        cmp_field("best_count", want.best_count, got.best_count);
      end
    end
    if (rst_n && in_bus.valid && in_bus.ready) begin
      moved = 1'b1;
      steps_sent++;
      want = predict_probe(in_bus.strobe_line, in_bus.sense_levels, in_bus.last_step);
      // typed-in rows override the per-step fields
      if (pin_now) begin
        want.hit_bits = pin_mask;
        want.hit_total = pin_cnt;
      end
      probe_results_due.push_back(want);
    end
    stall_cycles = moved ? 0 : stall_cycles + 1;
    if (stall_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Offer one probe step and wait until it is taken; starts and ends at a falling edge
  task automatic drive_probe(logic [3:0] drv, logic [15:0] lv, logic lst);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.strobe_line <= drv;
    in_bus.sense_levels <= lv;
    in_bus.last_step <= lst;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic settle_pending();
    in_bus.valid <= 1'b0;
    do @(negedge clk); while (probe_results_due.size() != 0);
  endtask

  // Write both line registers while idle
  task automatic set_lines(logic [15:0] conf, logic [15:0] alow);
    cfg_we <= 1'b1;
    cfg_index <= kls_pkg::CFG_CONFIGURED_LINES;
    cfg_data <= conf;
    @(negedge clk);
    cfg_index <= kls_pkg::CFG_ACTIVE_LOW_LINES;
    cfg_data <= alow;
    @(negedge clk);
    cfg_we <= 1'b0;
    lines_cfg = conf;
    lines_alow = alow;
    settings_used++;
  endtask

  // Stimulus
  initial begin
    logic [15:0] conf;
    logic [15:0] alow;
    logic [15:0] act;
    logic [15:0] lv;
    logic [3:0]  drv;
    int          left;

    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.strobe_line = '0;
    in_bus.sense_levels = '0;
    in_bus.last_step = 1'b0;
    lines_cfg = kls_pkg::CONFIGURED_RESET;
    lines_alow = kls_pkg::ACTIVE_LOW_RESET;
    scan_seen = '0;
    best_ok = 1'b0;
    best_line = '0;
    best_hits = '0;
    best_hits_n = '0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    pin_now = 1'b0;
    pin_mask = '0;
    pin_cnt = '0;
    left = 0;

    // is_cfg, conf, alow, drive, levels, last, pinned, pin_mask, pin_count
    dir_tab = '{
      // reset settings: nothing configured
      '{1'b0, 16'h0, 16'h0, 4'd0,  16'h0000, 1'b0, 1'b1, 16'h0000, 4'd0},
      '{1'b0, 16'h0, 16'h0, 4'd15, 16'hFFFF, 1'b1, 1'b1, 16'h0000, 4'd0},
      // all lines, active high
      '{1'b1, 16'hFFFF, 16'h0000, 4'd0, 16'h0, 1'b0, 1'b0, 16'h0, 4'd0},
      '{1'b0, 16'h0, 16'h0, 4'd0,  16'hFFFF, 1'b0, 1'b1, 16'hFFFE, 4'd15},
      // equal count, must not replace the best probe
      '{1'b0, 16'h0, 16'h0, 4'd15, 16'hFFFF, 1'b0, 1'b1, 16'h7FFF, 4'd15},
      '{1'b0, 16'h0, 16'h0, 4'd3,  16'h0000, 1'b0, 1'b1, 16'h0000, 4'd0},
      // only the driven line active
      '{1'b0, 16'h0, 16'h0, 4'd5,  16'h0020, 1'b0, 1'b1, 16'h0000, 4'd0},
      '{1'b0, 16'h0, 16'h0, 4'd8,  16'h0101, 1'b1, 1'b1, 16'h0001, 4'd1},
      // scan with no hits anywhere
      '{1'b0, 16'h0, 16'h0, 4'd1,  16'h0000, 1'b0, 1'b1, 16'h0000, 4'd0},
      '{1'b0, 16'h0, 16'h0, 4'd2,  16'h0004, 1'b1, 1'b1, 16'h0000, 4'd0},
      // one-step scan, summary holds its own step
      '{1'b0, 16'h0, 16'h0, 4'd4,  16'h8000, 1'b1, 1'b1, 16'h8000, 4'd1},
      // four lines wired, active low
      '{1'b1, 16'h00F0, 16'hFFFF, 4'd0, 16'h0, 1'b0, 1'b0, 16'h0, 4'd0},
      '{1'b0, 16'h0, 16'h0, 4'd4,  16'h0000, 1'b0, 1'b1, 16'h00E0, 4'd3},
      '{1'b0, 16'h0, 16'h0, 4'd0,  16'h0000, 1'b0, 1'b1, 16'h0000, 4'd0},
      '{1'b0, 16'h0, 16'h0, 4'd5,  16'hFF0F, 1'b0, 1'b1, 16'h00D0, 4'd3},
      '{1'b0, 16'h0, 16'h0, 4'd6,  16'hFFFF, 1'b0, 1'b1, 16'h0000, 4'd0},
      '{1'b0, 16'h0, 16'h0, 4'd7,  16'h0000, 1'b1, 1'b1, 16'h0070, 4'd3},
      // mixed polarity
      '{1'b1, 16'hA5A5, 16'h5A5A, 4'd0, 16'h0, 1'b0, 1'b0, 16'h0, 4'd0},
      '{1'b0, 16'h0, 16'h0, 4'd0,  16'h1234, 1'b0, 1'b0, 16'h0, 4'd0},
      '{1'b0, 16'h0, 16'h0, 4'd2,  16'hFFFF, 1'b0, 1'b0, 16'h0, 4'd0},
      '{1'b0, 16'h0, 16'h0, 4'd8,  16'h0000, 1'b0, 1'b0, 16'h0, 4'd0},
      '{1'b0, 16'h0, 16'h0, 4'd15, 16'hA5A5, 1'b1, 1'b0, 16'h0, 4'd0},
      // outermost lines only
      '{1'b1, 16'h8001, 16'h0000, 4'd0, 16'h0, 1'b0, 1'b0, 16'h0, 4'd0},
      '{1'b0, 16'h0, 16'h0, 4'd0,  16'h8000, 1'b0, 1'b1, 16'h8000, 4'd1},
      '{1'b0, 16'h0, 16'h0, 4'd15, 16'h0001, 1'b1, 1'b1, 16'h0001, 4'd1}
    };

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    for (int i = 0; i < DIR_N; i++) begin
      if (dir_tab[i].is_cfg) begin
        settle_pending();
        set_lines(dir_tab[i].conf, dir_tab[i].alow);
      end else begin
        pin_now = dir_tab[i].pinned;
        pin_mask = dir_tab[i].pin_mask;
        pin_cnt = dir_tab[i].pin_count;
        drive_probe(dir_tab[i].drive, dir_tab[i].levels, dir_tab[i].last);
      end
    end
    pin_now = 1'b0;

    // Random scans, one line setting per phase
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin conf = 16'hFFFF; alow = 16'h0000; end
        1: begin conf = 16'hFFFF; alow = 16'hFFFF; end
        3: begin conf = 16'h0000; alow = 16'($urandom); end
        4: begin conf = 16'($urandom); alow = 16'h0000; end
        5: begin conf = 16'hFFFF; alow = 16'($urandom); end
        7: begin conf = 16'($urandom); alow = 16'hFFFF; end
        default: begin conf = 16'($urandom); alow = 16'($urandom); end
      endcase
      // no idling in the closing phase
      if (ph == PHASES - 1) idle_on = 1'b0;
      settle_pending();
      set_lines(conf, alow);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 20) hold_req = 1'b1;
        if (ph == 4 && n == 50) settle_pending();
        if (left == 0) begin
          left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 8);
        end
        drv = 4'($urandom_range(0, 15));
        // mostly drive a wired line
        if (conf != 16'h0000 && $urandom_range(0, 3) != 0) begin
          while (!conf[drv]) drv = drv + 4'd1;
        end
        case ($urandom_range(0, 5))
          0: act = 16'hFFFF;
          1: act = 16'h0000;
          2: act = 16'h0001 << $urandom_range(0, 15);
          3: act = (16'h0001 << $urandom_range(0, 15)) | (16'h0001 << $urandom_range(0, 15));
          default: act = 16'($urandom);
        endcase
        // mostly polarity-corrected, sometimes raw noise
        lv = ($urandom_range(0, 4) == 0) ? act : act ^ alow;
        drive_probe(drv, lv, left == 1);
        left--;
      end
    end

    settle_pending();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Covered %0d probe steps in %0d completed scans under %0d line settings,",
             steps_sent, scans_seen, settings_used);
    $display("with %0d result items checked and %0d field mismatches.",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/kls_pkg.sv
sv/kls_in_if.sv
sv/kls_out_if.sv
sv/kls_probe.sv
sv/kls_accum.sv
sv/keypad_line_probe_scan.sv
tb/tb_keypad_line_probe_scan.sv
